FILE: sv/tlbf_pkg.sv
// ----------------------------------------------------------------------------
// TLB FIFO-replacement package
// Shared types and fixed field widths for the translation buffer.
// ----------------------------------------------------------------------------
package tlbf_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned VA_W    = 32;
  localparam int unsigned PA_W    = 20;
  localparam int unsigned STAMP_W = 32;

  // Request kinds.
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  // One request as held in the queue between front and back.
  typedef struct packed {
    op_t                op;
    logic [VA_W-1:0]    va;
    logic [PA_W-1:0]    pa;
    logic [STAMP_W-1:0] stamp;
  } req_t;

  // Handshake from the queue head to the back end.
  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

endpackage

FILE: sv/tlbf_front.sv
// ----------------------------------------------------------------------------
// TLB front end
// Accepts request transfers, decodes the request kind and holds them in a
// two-entry queue that the back end drains.
// ----------------------------------------------------------------------------
module tlbf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [tlbf_pkg::VA_W-1:0]    in_virtual_address,
  input  logic [tlbf_pkg::PA_W-1:0]    in_insert_physical_address,
  input  logic [tlbf_pkg::STAMP_W-1:0] in_timestamp,
  output tlbf_pkg::head_t              head,
  input  logic                         head_pop
);

  tlbf_pkg::req_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  tlbf_pkg::req_t new_req;

  // The queue is full at two entries; stall depends only on the fill level.
  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;

  // Decode the incoming transfer into a queue entry.
  always_comb begin
    new_req.op    = tlbf_pkg::op_t'(in_opcode);
    new_req.va    = in_virtual_address;
    new_req.pa    = in_insert_physical_address;
    new_req.stamp = in_timestamp;
  end

  // Head of the queue as seen by the back end.
  always_comb begin
    head.valid = (count_r != 2'd0);
    head.req   = mem_r[rd_ptr_r];
  end

  // Pointer and fill-level updates.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = head_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !head_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && head_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_req;
    end
  end

endmodule

FILE: sv/tlbf_back.sv
// ----------------------------------------------------------------------------
// TLB back end
// Holds the translation entries, answers lookups through a parallel tag
// compare, and fills or replaces entries on insert. A background scan finds
// the entry with the oldest creation stamp after every insert.
// ----------------------------------------------------------------------------
module tlbf_back #(
  parameter int unsigned TLB_ENTRIES      = 8,
  parameter int unsigned PAGE_OFFSET_BITS = 10,
  parameter int unsigned FRAME_BITS       = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tlbf_pkg::head_t           head,
  output logic                      head_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_hit,
  output logic [tlbf_pkg::PA_W-1:0] out_physical_address
);

  localparam int unsigned PAGE_W = tlbf_pkg::VA_W - PAGE_OFFSET_BITS;
  localparam int unsigned IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

  // Entry storage.
  logic [TLB_ENTRIES-1:0]           valid_r;
  logic [PAGE_W-1:0]                page_r  [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]            frame_r [TLB_ENTRIES];
  logic [tlbf_pkg::STAMP_W-1:0]     birth_r [TLB_ENTRIES];

  // Oldest-entry scan.
  logic                             rd_busy_r;
  logic [IDX_W-1:0]                 scan_idx_r;
  logic                             cmp_vld_r;
  logic [IDX_W-1:0]                 cmp_idx_r;
  logic [tlbf_pkg::STAMP_W-1:0]     birth_q_r;
  logic [IDX_W-1:0]                 best_idx_r;
  logic [tlbf_pkg::STAMP_W-1:0]     best_stamp_r;
  logic                             scan_busy;

  // Output register.
  logic                             out_valid_r;
  logic                             out_hit_r;
  logic [tlbf_pkg::PA_W-1:0]        out_pa_r;
  logic                             out_free;

  // Request decode.
  logic [PAGE_W-1:0]                req_page;
  logic [PAGE_OFFSET_BITS-1:0]      req_offset;
  logic [FRAME_BITS-1:0]            req_frame;
  logic                             is_lookup;
  logic                             is_insert;
  logic                             do_lookup;
  logic                             do_insert;

  // Lookup and fill selection.
  logic                             lk_hit;
  logic [FRAME_BITS-1:0]            lk_frame;
  logic [63:0]                      lk_pa_wide;
  logic [IDX_W-1:0]                 free_idx;
  logic [IDX_W-1:0]                 ins_idx;

  assign scan_busy = rd_busy_r || cmp_vld_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Split the request into page, offset and frame.
  always_comb begin
    req_page   = PAGE_W'(head.req.va >> PAGE_OFFSET_BITS);
    req_offset = head.req.va[PAGE_OFFSET_BITS-1:0];
    req_frame  = FRAME_BITS'(64'(head.req.pa) >> PAGE_OFFSET_BITS);
  end

  // Classify the head request and decide whether it can complete now.
  always_comb begin
    is_lookup = 1'b0;
    is_insert = 1'b0;
    case (head.req.op)
      tlbf_pkg::OP_LOOKUP: is_lookup = 1'b1;
      tlbf_pkg::OP_INSERT: is_insert = 1'b1;
      default:             is_lookup = 1'b0;
    endcase
    do_lookup = head.valid && is_lookup && out_free;
    do_insert = head.valid && is_insert && !scan_busy;
    head_pop  = do_lookup || do_insert;
  end

  // Parallel tag compare; the lowest matching index answers.
  always_comb begin
    lk_hit   = 1'b0;
    lk_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (page_r[i] == req_page)) begin
        lk_hit   = 1'b1;
        lk_frame = frame_r[i];
      end
    end
    lk_pa_wide = (64'(lk_frame) << PAGE_OFFSET_BITS) | 64'(req_offset);
  end

  // First invalid entry, else the oldest one found by the scan.
  always_comb begin
    free_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    ins_idx = (&valid_r) ? best_idx_r : free_idx;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_insert) begin
      valid_r[ins_idx] <= 1'b1;
    end
  end

  // Entry payload, written on insert.
  always_ff @(posedge clk) begin
    if (do_insert) begin
      page_r[ins_idx]  <= req_page;
      frame_r[ins_idx] <= req_frame;
      birth_r[ins_idx] <= head.req.stamp;
    end
  end

  // Scan control: restart after every insert, one stamp read per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_busy_r  <= 1'b0;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      best_idx_r <= '0;
    end else if (do_insert) begin
      rd_busy_r  <= 1'b1;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      best_idx_r <= '0;
    end else begin
      cmp_vld_r <= rd_busy_r;
      if (rd_busy_r) begin
        if (scan_idx_r == LAST_IDX) begin
          rd_busy_r <= 1'b0;
        end else begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
        end
      end
      if (cmp_vld_r && (birth_q_r < best_stamp_r)) begin
        best_idx_r <= cmp_idx_r;
      end
    end
  end

  // Scan datapath: registered stamp read, then compare with the running minimum.
  always_ff @(posedge clk) begin
    if (do_insert) begin
      best_stamp_r <= '1;
    end else if (cmp_vld_r && (birth_q_r < best_stamp_r)) begin
      best_stamp_r <= birth_q_r;
    end
    birth_q_r <= birth_r[scan_idx_r];
    cmp_idx_r <= scan_idx_r;
  end

  // Result register; a lookup loads it when it is empty or being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_lookup) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_lookup) begin
      out_hit_r <= lk_hit;
      out_pa_r  <= lk_hit ? lk_pa_wide[tlbf_pkg::PA_W-1:0] : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_physical_address = out_pa_r;

endmodule

FILE: sv/tlb_lookup_fifo_replace_unit.sv
// ----------------------------------------------------------------------------
// TLB lookup with FIFO replacement
// Fully associative translation buffer with oldest-stamp replacement.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/stall): a lookup (opcode 0) gives
// one transfer on the out_ channel with hit and the translated address; an
// insert (opcode 1) writes an entry and gives no result.
// A request passes a two-entry queue and then the back end. When nothing is
// waiting, a lookup is written into the queue and then into the result
// register that drives out_valid. Lookups complete at one per cycle while
// out_stall is low and no insert waits, set by the combinational tag compare.
// After an insert the back end scans the stored stamps one entry per cycle to
// find the oldest entry; the next insert waits for that scan to finish.
// Lookups proceed during the scan.
// Reset (rst_n low, synchronous) empties the queue, clears the result
// register and marks every entry invalid.
// When out_stall is high the result holds; the next lookup then waits at the
// head of the queue and further requests fill the queue until in_stall rises.
// ----------------------------------------------------------------------------
module tlb_lookup_fifo_replace_unit #(
  parameter int unsigned TLB_ENTRIES      = 8,
  parameter int unsigned PAGE_OFFSET_BITS = 10,
  parameter int unsigned FRAME_BITS       = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [tlbf_pkg::VA_W-1:0]    in_virtual_address,
  input  logic [tlbf_pkg::PA_W-1:0]    in_insert_physical_address,
  input  logic [tlbf_pkg::STAMP_W-1:0] in_timestamp,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic [tlbf_pkg::PA_W-1:0]    out_physical_address
);

  tlbf_pkg::head_t head;
  logic            head_pop;

  // Front end: request queue.
  tlbf_front u_front (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_opcode                  (in_opcode),
    .in_virtual_address         (in_virtual_address),
    .in_insert_physical_address (in_insert_physical_address),
    .in_timestamp               (in_timestamp),
    .head                       (head),
    .head_pop                   (head_pop)
  );

  // Back end: entries, lookup and replacement.
  tlbf_back #(
    .TLB_ENTRIES      (TLB_ENTRIES),
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
    .FRAME_BITS       (FRAME_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .head_pop             (head_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_hit              (out_hit),
    .out_physical_address (out_physical_address)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translation buffer testbench
// Drives lookups and inserts into the FIFO-replacement TLB and checks every
// lookup answer against a shadow copy of the entries kept in a scoreboard.
// ----------------------------------------------------------------------------

// Shadow of the TLB entries plus the queue of translations still to come out.
class tlb_shadow;
  localparam int unsigned DEPTH    = 8;
  localparam int unsigned OFF_BITS = 10;
  localparam int unsigned PFN_BITS = 10;
  localparam int unsigned VPN_BITS = tlbf_pkg::VA_W - OFF_BITS;

  typedef struct {
    logic                     hit;
    logic [tlbf_pkg::PA_W-1:0] pa;
  } xlat_t;

  bit                             slot_used [DEPTH];
  logic [VPN_BITS-1:0]            slot_vpn  [DEPTH];
  logic [PFN_BITS-1:0]            slot_pfn  [DEPTH];
  logic [tlbf_pkg::STAMP_W-1:0]   slot_born [DEPTH];
  xlat_t                          xlat_expected_q [$];
  int                             errors;

  function new();
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_vpn[i]  = '0;
      slot_pfn[i]  = '0;
      slot_born[i] = '0;
    end
    errors = 0;
  endfunction

  // First free slot, else the oldest stamp with the lowest index on a tie.
  function int unsigned victim_slot();
    int unsigned oldest;
    oldest = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!slot_used[i]) return i;
    end
    for (int i = 1; i < DEPTH; i++) begin
      if (slot_born[i] < slot_born[oldest]) oldest = i;
    end
    return oldest;
  endfunction

  // Update the shadow for one accepted request and queue the lookup answer.
  function void note_request(tlbf_pkg::op_t op, logic [tlbf_pkg::VA_W-1:0] va,
                             logic [tlbf_pkg::PA_W-1:0] pa_in,
                             logic [tlbf_pkg::STAMP_W-1:0] stamp);
    logic [VPN_BITS-1:0]       vpn;
    logic [OFF_BITS-1:0]       pg_off;
    logic [tlbf_pkg::PA_W-1:0] shifted;
    logic [31:0]               wide;
    int unsigned               slot;
    xlat_t                     answer;
    vpn    = va[tlbf_pkg::VA_W-1:OFF_BITS];
    pg_off = va[OFF_BITS-1:0];
    if (op == tlbf_pkg::OP_INSERT) begin
      slot            = victim_slot();
      shifted         = pa_in >> OFF_BITS;
      slot_used[slot] = 1'b1;
      slot_vpn[slot]  = vpn;
      slot_pfn[slot]  = shifted[PFN_BITS-1:0];
      slot_born[slot] = stamp;
      return;
    end
    answer.hit = 1'b0;
    answer.pa  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_used[i] && slot_vpn[i] == vpn) begin
        wide       = (32'(slot_pfn[i]) << OFF_BITS) + 32'(pg_off);
        answer.hit = 1'b1;
        answer.pa  = wide[tlbf_pkg::PA_W-1:0];
        break;
      end
    end
    xlat_expected_q.push_back(answer);
  endfunction

  // Compare one result transfer with the oldest queued answer.
  function void check_translation(logic hit, logic [tlbf_pkg::PA_W-1:0] pa);
    xlat_t want;
    if (xlat_expected_q.size() == 0) begin
      $display("%0t: unexpected result, actual hit %0b pa %05h", $time, hit, pa);
      errors++;
      return;
    end
    want = xlat_expected_q.pop_front();
    if (hit !== want.hit) begin
      $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, hit);
      errors++;
    end
    if (pa !== want.pa) begin
      $display("%0t: physical_address mismatch, expected %05h, actual %05h",
               $time, want.pa, pa);
      errors++;
    end
  endfunction

  function int pending();
    return xlat_expected_q.size();
  endfunction
endclass

module tb;

  localparam int unsigned VA_W        = tlbf_pkg::VA_W;
  localparam int unsigned PA_W        = tlbf_pkg::PA_W;
  localparam int unsigned STAMP_W     = tlbf_pkg::STAMP_W;
  localparam int unsigned TLB_DEPTH   = 8;
  localparam int unsigned OFF_BITS    = 10;
  localparam int unsigned VPN_BITS    = VA_W - OFF_BITS;
  localparam int unsigned RAND_ITEMS  = 1530;
  localparam int unsigned POOL_SIZE   = 12;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_opcode = 1'b0;
  logic [VA_W-1:0]    in_virtual_address = '0;
  logic [PA_W-1:0]    in_insert_physical_address = '0;
  logic [STAMP_W-1:0] in_timestamp = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic [PA_W-1:0]    out_physical_address;

  tlb_shadow          sb;
  bit                 long_hold_req = 1'b0;
  int unsigned        burst_left = 0;
  int unsigned        cycle_count = 0;
  logic [VPN_BITS-1:0]  vpn_pool [POOL_SIZE];
  logic [STAMP_W-1:0]   stamp_clock = '0;
  logic [STAMP_W-1:0]   last_stamp = '0;

  tlb_lookup_fifo_replace_unit #(
    .TLB_ENTRIES      (TLB_DEPTH),
    .PAGE_OFFSET_BITS (OFF_BITS),
    .FRAME_BITS       (10)
  ) dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_opcode                  (in_opcode),
    .in_virtual_address         (in_virtual_address),
    .in_insert_physical_address (in_insert_physical_address),
    .in_timestamp               (in_timestamp),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_hit                    (out_hit),
    .out_physical_address       (out_physical_address)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: cycle limit reached");
      $display("tb: done, errors");
      $finish;
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_translation(out_hit, out_physical_address);
    end
  end

  // Result side stall pattern, with a long hold-off when the sender asks.
  initial begin : result_stall
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 200);
        end
        mode_left--;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_stall <= ($urandom_range(0, 9) < 7);
          end
        endcase
      end
    end
  end

  // Offer one request, with a random gap first when the burst has run out.
  // Called and left at a falling edge.
  task automatic send_req(tlbf_pkg::op_t op, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                          logic [STAMP_W-1:0] stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                              : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid                   <= 1'b1;
    in_opcode                  <= op;
    in_virtual_address         <= va;
    in_insert_physical_address <= pa;
    in_timestamp               <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, va, pa, stamp);
    @(negedge clk);
  endtask

  // Stop offering until every lookup answer has come and the replacement
  // scan after the last insert has had time to finish.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TLB_DEPTH + 4) @(negedge clk);
  endtask

  function automatic logic [VA_W-1:0] page_va(logic [VPN_BITS-1:0] vpn,
                                              logic [OFF_BITS-1:0] pg_off);
    return {vpn, pg_off};
  endfunction

  // Stamp drawn from a mix of rising, random, extreme and repeated values.
  function automatic logic [STAMP_W-1:0] pick_stamp();
    int unsigned sel;
    logic [STAMP_W-1:0] s;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      stamp_clock = stamp_clock + $urandom_range(0, 3);
      s = stamp_clock;
    end else if (sel < 7) begin
      s = $urandom();
    end else if (sel < 8) begin
      s = ($urandom_range(0, 1) == 0) ? '0 : '1;
    end else begin
      s = last_stamp;
    end
    last_stamp = s;
    return s;
  endfunction

  // Random request: mostly pages from a small pool so lookups hit often.
  task automatic send_random(bit force_lookup);
    tlbf_pkg::op_t    op;
    logic [VA_W-1:0]  va;
    if (force_lookup || $urandom_range(0, 99) >= 30) op = tlbf_pkg::OP_LOOKUP;
    else op = tlbf_pkg::OP_INSERT;
    if ($urandom_range(0, 99) < 12) va = $urandom();
    else va = page_va(vpn_pool[$urandom_range(0, POOL_SIZE - 1)], OFF_BITS'($urandom()));
    if ($urandom_range(0, 99) < 3) begin
      vpn_pool[$urandom_range(0, POOL_SIZE - 1)] = VPN_BITS'($urandom());
    end
    send_req(op, va, PA_W'($urandom()), pick_stamp());
  endtask

  // Main sequence.
  initial begin : main_seq
    int unsigned wait_cycles;
    sb = new();
    for (int i = 0; i < POOL_SIZE; i++) vpn_pool[i] = VPN_BITS'($urandom());
    vpn_pool[0] = '0;
    vpn_pool[1] = '1;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty buffer, extreme pages, frames and stamps.
    send_req(tlbf_pkg::OP_LOOKUP, 32'h0000_0000, 20'hFFFFF, 32'hFFFF_FFFF);
    send_req(tlbf_pkg::OP_INSERT, 32'h0000_0000, 20'hFFFFF, 32'hFFFF_FFFF);
    send_req(tlbf_pkg::OP_LOOKUP, 32'h0000_03FF, 20'h00000, 32'h0000_0000);
    send_req(tlbf_pkg::OP_LOOKUP, 32'h0000_0400, 20'h00000, 32'h0000_0000);
    send_req(tlbf_pkg::OP_INSERT, 32'hFFFF_FFFF, 20'h00000, 32'h0000_0000);
    send_req(tlbf_pkg::OP_LOOKUP, 32'hFFFF_FC00, 20'hFFFFF, 32'hFFFF_FFFF);
    send_req(tlbf_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 20'h00000, 32'h0000_0000);
    // A second entry for a page already present; the lower slot answers.
    send_req(tlbf_pkg::OP_INSERT, 32'h0000_0155, 20'h55400, 32'h0000_0005);
    send_req(tlbf_pkg::OP_LOOKUP, 32'h0000_0123, 20'h00000, 32'h0000_0000);
    // Fill the remaining slots, some with equal stamps.
    send_req(tlbf_pkg::OP_INSERT, page_va(22'd10, 10'h0), 20'h0A800, 32'd7);
    send_req(tlbf_pkg::OP_INSERT, page_va(22'd11, 10'h0), 20'h0B800, 32'd7);
    send_req(tlbf_pkg::OP_INSERT, page_va(22'd12, 10'h0), 20'h0C800, 32'd9);
    send_req(tlbf_pkg::OP_INSERT, page_va(22'd13, 10'h0), 20'h0D800, 32'd3);
    send_req(tlbf_pkg::OP_INSERT, page_va(22'd14, 10'h0), 20'h0E800, 32'd7);
    // Full buffer: replacements by oldest stamp, lowest slot on a tie.
    send_req(tlbf_pkg::OP_INSERT, page_va(22'd20, 10'h0), 20'h14400, 32'd100);
    send_req(tlbf_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 20'h00000, 32'h0000_0000);
    send_req(tlbf_pkg::OP_INSERT, page_va(22'd21, 10'h0), 20'h15400, 32'd100);
    send_req(tlbf_pkg::OP_INSERT, page_va(22'd22, 10'h0), 20'h16400, 32'd100);
    send_req(tlbf_pkg::OP_INSERT, page_va(22'd23, 10'h0), 20'h17400, 32'd50);
    send_req(tlbf_pkg::OP_INSERT, page_va(22'd24, 10'h0), 20'h18400, 32'd50);
    send_req(tlbf_pkg::OP_LOOKUP, page_va(22'd23, 10'h02A), 20'hABCDE, 32'h1234_5678);
    send_req(tlbf_pkg::OP_LOOKUP, page_va(22'd0, 10'h3FF), 20'h00000, 32'h0000_0000);
    send_req(tlbf_pkg::OP_LOOKUP, page_va(22'd12, 10'h155), 20'h00000, 32'h0000_0000);
    send_req(tlbf_pkg::OP_LOOKUP, page_va(22'd10, 10'h001), 20'h00000, 32'h0000_0000);
    drain_results();

    // Random traffic with hold-offs and full drains along the way.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 400 || n == 1100) begin
        // Long receiver hold while the sender keeps offering lookups.
        long_hold_req = 1'b1;
        burst_left    = 20;
        for (int k = 0; k < 16; k++) send_random(1'b1);
      end
      if (n == 700 || n == 1300) drain_results();
      send_random(1'b0);
    end

    // Wait for the last answers, then watch for any stray transfer.
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (TLB_DEPTH + 12) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
